FILE: hw/rtl/u2h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2h_pkg - shared types and constants for the UTF-8 to UCS-2 hex encoder
// Decode modes, job record passed from front to back, ASCII helpers.
// ----------------------------------------------------------------------------
package u2h_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 11;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 9;
    localparam int LIMIT_W = 8;

    localparam logic [BYTE_W-1:0]  ASCII_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0]  LEAD2_MASK    = 8'hE0;
    localparam logic [BYTE_W-1:0]  LEAD2_CODE    = 8'hC0;
    localparam logic [BYTE_W-1:0]  LEAD3_MASK    = 8'hF0;
    localparam logic [BYTE_W-1:0]  LEAD3_CODE    = 8'hE0;
    localparam logic [UNIT_W-1:0]  UNIT_QUESTION = 11'h03F;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd139;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_HELD  = 2'd1,
        MODE_SKIP2 = 2'd2,
        MODE_SKIP1 = 2'd3
    } t_mode;

    typedef struct packed {
        logic               has_unit;
        logic               is_term;
        logic [UNIT_W-1:0]  unit;
        logic [COUNT_W-1:0] nbytes;
    } t_job;

    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 4'd10) begin
            r = 7'h30 + {3'b000, v};
        end else begin
            r = 7'h37 + {3'b000, v};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/u2h_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2h_front - UTF-8 byte classifier
// Tracks multi-byte sequences and unit count, emits one job per code unit
// or terminator into the job queue.
// ----------------------------------------------------------------------------
module u2h_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [u2h_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                         i_end,
    input  wire logic [u2h_pkg::LIMIT_W-1:0]  i_max_units,
    output u2h_pkg::t_job                     o_job,
    output logic                              o_push
);
    import u2h_pkg::*;

    t_mode              r_mode, n_mode;
    logic [4:0]         r_held, n_held;
    logic [LIMIT_W-1:0] r_units, n_units;
    logic               w_room;

    assign w_room = (r_units < i_max_units);

    // next state
    always_comb begin
        n_mode = r_mode;
        if (i_accept) begin
            if (i_end) begin
                n_mode = MODE_IDLE;
            end else if (w_room) begin
                unique case (r_mode)
                    MODE_HELD:  n_mode = MODE_IDLE;
                    MODE_SKIP2: n_mode = MODE_SKIP1;
                    MODE_SKIP1: n_mode = MODE_IDLE;
                    MODE_IDLE: begin
                        if ((i_byte & LEAD2_MASK) == LEAD2_CODE) begin
                            n_mode = MODE_HELD;
                        end else if ((i_byte & LEAD3_MASK) == LEAD3_CODE) begin
                            n_mode = MODE_SKIP2;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default:    n_mode = MODE_IDLE;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        o_push         = 1'b0;
        o_job.has_unit = 1'b0;
        o_job.is_term  = 1'b0;
        o_job.unit     = '0;
        n_held         = r_held;
        n_units        = r_units;
        if (i_accept) begin
            if (i_end) begin
                o_push        = 1'b1;
                o_job.is_term = 1'b1;
                o_job.unit    = {r_held, 6'b000000};
                if (r_mode == MODE_HELD && w_room) begin
                    o_job.has_unit = 1'b1;
                    n_units        = r_units + 1'b1;
                end
            end else if (w_room) begin
                unique case (r_mode)
                    MODE_HELD: begin
                        o_push         = 1'b1;
                        o_job.has_unit = 1'b1;
                        o_job.unit     = {r_held, i_byte[5:0]};
                    end
                    MODE_SKIP2, MODE_SKIP1: begin
                        o_push = 1'b0;
                    end
                    MODE_IDLE: begin
                        if (i_byte < ASCII_LIMIT) begin
                            o_push         = 1'b1;
                            o_job.has_unit = 1'b1;
                            o_job.unit     = {3'b000, i_byte};
                        end else if ((i_byte & LEAD2_MASK) == LEAD2_CODE) begin
                            n_held = i_byte[4:0];
                        end else begin
                            o_push         = 1'b1;
                            o_job.has_unit = 1'b1;
                            o_job.unit     = UNIT_QUESTION;
                        end
                    end
                    default: o_push = 1'b0;
                endcase
                if (o_push) begin
                    n_units = r_units + 1'b1;
                end
            end
        end
        o_job.nbytes = {n_units, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= '0;
            r_units <= '0;
        end else if (i_accept && i_end) begin
            r_mode  <= MODE_IDLE;
            r_held  <= '0;
            r_units <= '0;
        end else begin
            r_mode  <= n_mode;
            r_held  <= (n_mode == MODE_IDLE) ? 5'b00000 : n_held;
            r_units <= n_units;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/u2h_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2h_fifo - job queue between classifier and hex emitter
// Register-based FIFO with show-ahead read.
// ----------------------------------------------------------------------------
module u2h_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire u2h_pkg::t_job i_job,
    input  wire logic          i_pop,
    output u2h_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import u2h_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign o_job     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/u2h_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2h_back - hex character emitter
// Expands each job into four ASCII hex characters and/or a terminator,
// one per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u2h_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire u2h_pkg::t_job                i_job,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [u2h_pkg::CHAR_W-1:0]        o_char,
    output logic [u2h_pkg::COUNT_W-1:0]       o_count,
    output logic                              o_last
);
    import u2h_pkg::*;

    localparam logic [2:0] STEP_TERM = 3'd4;

    t_job               r_job;
    logic               r_busy;
    logic [2:0]         r_step;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic [COUNT_W-1:0] r_count;
    logic               r_last;
    logic               w_adv, w_done;
    logic [15:0]        w_word;
    logic [3:0]         w_nib;

    assign w_adv  = r_busy && (!r_valid || i_ready);
    assign w_done = (r_step == STEP_TERM) || (r_step == 3'd3 && !r_job.is_term);
    assign o_pop  = !i_empty && (!r_busy || (w_adv && w_done));
    assign w_word = {5'b00000, r_job.unit};

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    w_nib = w_word[15:12];
            2'd1:    w_nib = w_word[11:8];
            2'd2:    w_nib = w_word[7:4];
            default: w_nib = w_word[3:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_adv) begin
            r_char  <= (r_step == STEP_TERM) ? '0 : hex_ascii(w_nib);
            r_count <= r_job.nbytes;
            r_last  <= (r_step == STEP_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= i_job.has_unit ? 3'd0 : STEP_TERM;
            end else if (w_adv) begin
                r_busy <= !w_done;
                r_step <= (r_step == 3'd3) ? STEP_TERM : r_step + 1'b1;
            end
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_count = r_count;
    assign o_last  = r_last;

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_to_ucs2_hex_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ucs2_hex_encoder - UTF-8 text to UCS-2 big-endian ASCII hex
// Classifier front, job queue, hex emitter back.
//
//  channel | dir | tdata                                  | tlast
//  s_axis  | in  | [7:0] text_byte                        | end_of_text
//  m_axis  | out | [6:0] hex_char, [15:7] user_data_bytes | is_last
//  cfg     | in  | [7:0] max_units                        | -
//
//  Input side takes one byte per cycle while the job queue has room.
//  Each code unit yields four output characters, the terminator one; the
//  one-character output register sets the sustained output rate.
//  Output register decouples tready stalls; the queue absorbs input bursts.
//  Synchronous active-low reset clears all control state; max_units = 139.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_hex_encoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_byte
    input  wire logic        s_axis_tlast,  // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [6:0] hex_char, [15:7] user_data_bytes
    output logic             m_axis_tlast,  // is_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data       // [7:0] max_units
);
    import u2h_pkg::*;

    logic [LIMIT_W-1:0] r_max_units;
    t_job               w_push_job, w_pop_job;
    logic               w_push, w_pop, w_full, w_empty, w_accept;
    logic [CHAR_W-1:0]  w_char;
    logic [COUNT_W-1:0] w_count;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= LIMIT_RESET;
        end else if (cfg_valid) begin
            r_max_units <= cfg_data;
        end
    end

    u2h_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_max_units (r_max_units),
        .o_job       (w_push_job),
        .o_push      (w_push)
    );

    u2h_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    u2h_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_pop_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (w_char),
        .o_count (w_count),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_count, w_char};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job queue overflow");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (w_char == '0))
        else $error("terminator carries a character");

    a_char_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (w_char >= 7'h30 && w_char <= 7'h46))
        else $error("non-hex character emitted");

endmodule
`default_nettype wire
